// ----- rtl/fse_pkg.sv -----
// Shared widths and item types for the Fermat step estimate block.
package fse_pkg;

  localparam int unsigned FIELD_BITS = 64;
  localparam int unsigned START_BITS = 33;

  typedef struct packed {
    logic [FIELD_BITS-1:0] modulus;
    logic [FIELD_BITS-1:0] factor_one;
    logic [FIELD_BITS-1:0] factor_two;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] step_count;
    logic                  incompatible;
    logic [START_BITS-1:0] search_start;
  } out_item_t;

endpackage

// ----- rtl/fse_in_if.sv -----
// Valid/ready channel carrying one modulus and factor pair per transaction.
interface fse_in_if;
  logic              valid;
  logic              ready;
  fse_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/fse_out_if.sv -----
// Valid/ready channel carrying one step estimate result per transaction.
interface fse_out_if;
  logic               valid;
  logic               ready;
  fse_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/fermat_step_estimate.sv -----
// An accepted transaction passes through the square root stages, a rounding stage and a subtraction stage.
// Takes one transaction per cycle while the output is not stalled; the square root takes one result bit per stage.
// Every stage has its own valid bit and takes new data when it is empty or its successor moves,
// so bubbles close up and a stalled output still lets earlier stages fill.
// Reset (rst, synchronous) empties all stages; payload registers are not reset.
module fermat_step_estimate #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic      clk,
  input  logic      rst,
  fse_in_if.sink    items,
  fse_out_if.source results
);

  // Number of root bits, one bit pair of the operand per stage.
  localparam int unsigned NB = (WORD_BITS + 1) / 2;
  localparam int unsigned PW = 2 * NB;
  localparam int unsigned S  = NB + 2;

  logic [S-1:0] vld;
  logic [S:0]   rdy;

  // Square root stages.
  logic [NB:0]      sq_rem  [NB];
  logic [NB-1:0]    sq_root [NB];
  logic [PW-1:0]    sq_n    [NB-1];

  // Factor path travelling alongside the root.
  logic [WORD_BITS-1:0] fa  [NB];
  logic [WORD_BITS-1:0] fb  [2];
  logic                 bad [NB];

  // Rounding and subtraction stages.
  logic [NB:0]          cs_start;
  logic [WORD_BITS-1:0] cs_mid;
  logic                 cs_bad;
  logic [NB:0]          out_start;
  logic [WORD_BITS-1:0] out_steps;
  logic                 out_bad;

  logic [WORD_BITS-1:0] in_mod;
  logic [WORD_BITS-1:0] in_f1;
  logic [WORD_BITS-1:0] in_f2;

  assign in_mod = items.data.modulus[WORD_BITS-1:0];
  assign in_f1  = items.data.factor_one[WORD_BITS-1:0];
  assign in_f2  = items.data.factor_two[WORD_BITS-1:0];

  assign rdy[S] = results.ready;
  for (genvar k = 0; k < S; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign items.ready = rdy[0];

  for (genvar j = 0; j < NB; j++) begin : g_sq
    logic [NB:0]   rem_p;
    logic [NB-1:0] root_p;
    logic [PW-1:0] n_p;
    logic          vld_p;
    logic [NB+2:0] rem_t;
    logic [NB+2:0] trial;
    logic [NB+2:0] diff;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign n_p    = PW'(in_mod);
      assign vld_p  = items.valid;
    end else begin : g_next
      assign rem_p  = sq_rem[j-1];
      assign root_p = sq_root[j-1];
      assign n_p    = sq_n[j-1];
      assign vld_p  = vld[j-1];
    end

    assign rem_t = {rem_p, n_p[PW-1 -: 2]};
    assign trial = (NB+3)'({root_p, 2'b01});
    assign ge    = rem_t >= trial;
    assign diff  = rem_t - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (rdy[j]) begin
        vld[j] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j] && vld_p) begin
        sq_rem[j]  <= ge ? diff[NB:0] : rem_t[NB:0];
        sq_root[j] <= {root_p[NB-2:0], ge};
      end
    end

    if (j < NB - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (rdy[j] && vld_p) begin
          sq_n[j] <= n_p << 2;
        end
      end
    end

    // Factor ordering, half difference and midpoint take the first three stages.
    if (j == 0) begin : g_order
      always_ff @(posedge clk) begin
        if (rdy[j] && vld_p) begin
          fa[j]  <= (in_f1 < in_f2) ? in_f1 : in_f2;
          fb[0]  <= (in_f1 < in_f2) ? in_f2 : in_f1;
          bad[j] <= in_f1[0] ^ in_f2[0];
        end
      end
    end else if (j == 1) begin : g_half
      always_ff @(posedge clk) begin
        if (rdy[j] && vld_p) begin
          fa[j]  <= fa[j-1];
          fb[1]  <= (fb[0] - fa[j-1]) >> 1;
          bad[j] <= bad[j-1];
        end
      end
    end else if (j == 2) begin : g_mid
      always_ff @(posedge clk) begin
        if (rdy[j] && vld_p) begin
          fa[j]  <= fa[j-1] + fb[1];
          bad[j] <= bad[j-1];
        end
      end
    end else begin : g_carry
      always_ff @(posedge clk) begin
        if (rdy[j] && vld_p) begin
          fa[j]  <= fa[j-1];
          bad[j] <= bad[j-1];
        end
      end
    end
  end

  // A nonzero remainder means the floor root squared falls short, so round up.
  // This also gives zero and one for a modulus of zero and one.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[NB] <= 1'b0;
    end else if (rdy[NB]) begin
      vld[NB] <= vld[NB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NB] && vld[NB-1]) begin
      cs_start <= (NB+1)'(sq_root[NB-1]) + (NB+1)'(|sq_rem[NB-1]);
      cs_mid   <= fa[NB-1];
      cs_bad   <= bad[NB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[NB+1] <= 1'b0;
    end else if (rdy[NB+1]) begin
      vld[NB+1] <= vld[NB];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NB+1] && vld[NB]) begin
      out_start <= cs_start;
      out_bad   <= cs_bad;
      if (cs_bad) begin
        out_steps <= '1;
      end else if (cs_mid >= WORD_BITS'(cs_start)) begin
        out_steps <= cs_mid - WORD_BITS'(cs_start);
      end else begin
        out_steps <= '0;
      end
    end
  end

  assign results.valid             = vld[S-1];
  assign results.data.step_count   = fse_pkg::FIELD_BITS'(out_steps);
  assign results.data.incompatible = out_bad;
  assign results.data.search_start = fse_pkg::START_BITS'(out_start);

endmodule

// ----- rtl/fse_checker.sv -----
// Port-level assertions for the Fermat step estimate block, with the bind that attaches them.
module fse_checker #(
  parameter int unsigned WORD_BITS = 64
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [fse_pkg::FIELD_BITS-1:0]      step_count,
  input logic                                incompatible,
  input logic [fse_pkg::START_BITS-1:0]      search_start
);

  localparam logic [fse_pkg::FIELD_BITS-1:0] ONES =
    fse_pkg::FIELD_BITS'((65'd1 << WORD_BITS) - 65'd1);
  localparam logic [fse_pkg::START_BITS-1:0] START_MAX = 33'h1_0000_0000;

  // A stalled result must hold until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(step_count) &&
      $stable(incompatible) && $stable(search_start))
    else $error("result changed while stalled");

  // A mismatched parity pair always reports the full-word step count.
  a_bad_ones: assert property (@(posedge clk) disable iff (rst)
    out_valid && incompatible |-> step_count == ONES)
    else $error("incompatible result without all-ones step count");

  // The rounded-up root of a 64-bit modulus never exceeds two to the 32nd.
  a_start_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> search_start <= START_MAX)
    else $error("search start out of range");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind fermat_step_estimate fse_checker #(.WORD_BITS(WORD_BITS)) u_fse_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .step_count   (results.data.step_count),
  .incompatible (results.data.incompatible),
  .search_start (results.data.search_start)
);
